// ----- rtl/core/ccq_pkg.sv -----
// shared types and defaults for the coalescing count queue
package ccq_pkg;

  localparam int unsigned CcqEntries   = 16;
  localparam int unsigned CcqValueBits = 32;
  localparam int unsigned CcqCountBits = 16;

  typedef enum logic [2:0] {
    STATUS_APPENDED  = 3'd0,
    STATUS_MERGED    = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_EXTRACTED = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_e;

  typedef enum logic {
    MODE_INSERT  = 1'b0,
    MODE_EXTRACT = 1'b1
  } mode_e;

  // broadcast controls from the top level to every cell
  typedef struct packed {
    logic shift;     // head leaves, every cell takes its upper neighbor
    logic dec_head;  // head hands out one extra copy
    logic merge;     // insert word, matching cell counts one more copy
    logic append;    // insert word missed, first free cell takes it
  } ccq_ctrl_t;

endpackage

// ----- rtl/core/ccq_cell.sv -----
// one queue slot: value, extra copy count and valid, shifts toward the head
module ccq_cell #(
  parameter int unsigned VALUE_BITS = ccq_pkg::CcqValueBits,
  parameter int unsigned COUNT_BITS = ccq_pkg::CcqCountBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ccq_pkg::ccq_ctrl_t    ctrl_i,
  input  logic                  is_head_i,
  input  logic [VALUE_BITS-1:0] ins_value_i,
  input  logic                  prev_valid_i,
  input  logic                  next_valid_i,
  input  logic [VALUE_BITS-1:0] next_value_i,
  input  logic [COUNT_BITS-1:0] next_count_i,
  output logic                  valid_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  match_o
);
  import ccq_pkg::*;

  logic                  valid_q, valid_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  assign match_o = valid_q && (value_q == ins_value_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    count_d = count_q;
    if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      value_d = next_value_i;
      count_d = next_count_i;
    end else if (ctrl_i.dec_head && is_head_i) begin
      count_d = count_q - COUNT_BITS'(1);
    end else if (ctrl_i.merge && match_o) begin
      // saturate at the count maximum
      if (count_q != {COUNT_BITS{1'b1}}) begin
        count_d = count_q + COUNT_BITS'(1);
      end
    end else if (ctrl_i.append && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      value_d = ins_value_i;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    count_q <= count_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign count_o = count_q;

endmodule

// ----- rtl/core/coalescing_count_queue.sv -----
// top level of the coalescing count queue: cell row, control and result register
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid_i, in_stall_o, mode_i, value_i | in
//  out     | out_valid_o, out_stall_i, out_value_o,  | out
//          | status_o, is_empty_o                    |
//
// one word per cycle unless stalled: the search compares every cell at once and
// the whole operation finishes in the cycle the word is accepted; its result
// is in the output register the next cycle. reset empties the row at once, no
// clearing pass. in_stall_o rises only while a result waits under out_stall_i.
module coalescing_count_queue #(
  parameter int unsigned ENTRIES    = ccq_pkg::CcqEntries,
  parameter int unsigned VALUE_BITS = ccq_pkg::CcqValueBits,
  parameter int unsigned COUNT_BITS = ccq_pkg::CcqCountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_value_o,
  output logic [2:0]  status_o,
  output logic        is_empty_o
);
  import ccq_pkg::*;

  logic                  valid_w [ENTRIES];
  logic [VALUE_BITS-1:0] value_w [ENTRIES];
  logic [COUNT_BITS-1:0] count_w [ENTRIES];
  logic [ENTRIES-1:0]    valid_vec;
  logic [ENTRIES-1:0]    match_vec;

  logic [VALUE_BITS-1:0] ins_value;
  logic [31:0]           head_word;
  logic                  accept;
  logic                  is_ins, is_ext;
  logic                  hit, full, head_last;
  ccq_ctrl_t             ctrl;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_value_q, out_value_d;
  status_e     status_q, status_d;
  logic        empty_q, empty_d;

  // value conversion between the 32-bit word and the stored width
  if (VALUE_BITS <= 32) begin : g_ins_narrow
    assign ins_value = value_i[VALUE_BITS-1:0];
  end else begin : g_ins_wide
    assign ins_value = {{(VALUE_BITS-32){value_i[31]}}, value_i};
  end

  if (VALUE_BITS >= 32) begin : g_out_narrow
    assign head_word = value_w[0][31:0];
  end else begin : g_out_wide
    assign head_word = {{(32-VALUE_BITS){value_w[0][VALUE_BITS-1]}}, value_w[0]};
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_ins     = accept && (mode_i == MODE_INSERT);
  assign is_ext     = accept && (mode_i == MODE_EXTRACT);

  assign hit       = |match_vec;
  assign full      = valid_w[ENTRIES-1];
  assign head_last = valid_w[0] && (count_w[0] == '0);

  assign ctrl.shift    = is_ext && head_last;
  assign ctrl.dec_head = is_ext && valid_w[0] && (count_w[0] != '0);
  assign ctrl.merge    = is_ins;
  assign ctrl.append   = is_ins && !hit;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                  prev_valid;
    logic                  next_valid;
    logic [VALUE_BITS-1:0] next_value;
    logic [COUNT_BITS-1:0] next_count;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = valid_w[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_value = '0;
      assign next_count = '0;
    end else begin : g_inner
      assign next_valid = valid_w[i+1];
      assign next_value = value_w[i+1];
      assign next_count = count_w[i+1];
    end

    ccq_cell #(
      .VALUE_BITS (VALUE_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .is_head_i    (i == 0),
      .ins_value_i  (ins_value),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_value_i (next_value),
      .next_count_i (next_count),
      .valid_o      (valid_w[i]),
      .value_o      (value_w[i]),
      .count_o      (count_w[i]),
      .match_o      (match_vec[i])
    );

    assign valid_vec[i] = valid_w[i];
  end

  always_comb begin
    out_value_d = '0;
    empty_d     = 1'b0;
    if (is_ins) begin
      if (hit) begin
        status_d = STATUS_MERGED;
      end else if (full) begin
        status_d = STATUS_FULL;
      end else begin
        status_d = STATUS_APPENDED;
      end
    end else if (valid_w[0]) begin
      status_d    = STATUS_EXTRACTED;
      out_value_d = head_word;
      empty_d     = head_last && !valid_w[1];
    end else begin
      status_d = STATUS_EMPTY;
      empty_d  = 1'b1;
    end
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q <= out_value_d;
      status_q    <= status_d;
      empty_q     <= empty_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign is_empty_o  = empty_q;

  // occupied cells always form one run starting at the head
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, valid_vec} + (ENTRIES+1)'(1)))
    else $error("queue cells not contiguous");

  // stored values stay distinct
  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("more than one cell matched");

  // head with extra copies stays in place after an extract
  a_head_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.dec_head |=> valid_w[0])
    else $error("head lost while copies remain");

  // a missed insert into a full row reports a drop and keeps the row full
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_ins && !hit && full) |=> (status_o == STATUS_FULL) && valid_w[ENTRIES-1])
    else $error("full insert not dropped");

endmodule
